>>> hw/rtl/rational_arithmetic_unit_assert.svh
// ============================================================================
// Assertion macros for the rational arithmetic unit
// Shared property forms used by the checks at the end of the top level.
// ============================================================================
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define RAU_AST_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle.
`define RAU_AST_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rau_pkg.sv
// ============================================================================
// rau_pkg
// Widths, codes and controller/datapath interface types of the rational unit.
// ============================================================================
package rau_pkg;

    localparam int FW     = 64;              // width of every operand field
    localparam int WIDTH  = 64;              // significant operand bits, 8..64
    localparam int W      = WIDTH;
    localparam int PW     = 2 * W;           // product width
    localparam int MW     = PW + 1;          // magnitude of a sum of products
    localparam int SW     = PW + 2;          // signed sum of products
    localparam int MCW    = $clog2(W);       // width of the multiplier iteration counter
    localparam int DCW    = $clog2(MW);      // width of the divider iteration counter
    localparam int IN_DW  = 4 * FW;
    localparam int OUT_DW = ((FW + (FW - 1) + 2 + 7) / 8) * 8;

    localparam logic [MW-1:0] LIM    = MW'(1) << (W - 1);
    localparam logic [MW-1:0] LIM_M1 = LIM - MW'(1);

    localparam logic [2:0] F_RED = 3'd0;
    localparam logic [2:0] F_ADD = 3'd1;
    localparam logic [2:0] F_SUB = 3'd2;
    localparam logic [2:0] F_MUL = 3'd3;
    localparam logic [2:0] F_DIV = 3'd4;
    localparam logic [2:0] F_NEG = 3'd5;
    localparam logic [2:0] F_CMP = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_MUL_START, DP_MUL_RUN, DP_COMB, DP_ABS,
        DP_GCD, DP_DIV_START, DP_DIV_RUN, DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] step;   // which of the three products
        logic       dsel;   // 0 divides the numerator, 1 the denominator
    } t_cmd;

    typedef struct packed {
        logic spec;         // result is fixed 0/1 with a known status
        logic mul_done;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_stat;

    // Magnitude of a two's complement operand; the most negative value fits.
    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? W'(-x) : x;
    endfunction

endpackage

>>> hw/rtl/rational_arithmetic_unit.sv
// ============================================================================
// rational_arithmetic_unit
// Exact rational reduce, add, subtract, multiply, divide, negate and compare.
// ============================================================================
//
//   Channel   Direction  tdata (low bit up)                        tuser
//   s_axis    in         a_num, a_den, b_num, b_den (4 x 64)        func (3)
//   m_axis    out        res_num(64), res_den(63), less, equal, pad status (2)
//
// One transaction is worked on at a time. An item with a zero denominator or
// the unused code only goes through accept, check and finish. Otherwise three
// shift-add products come first, after which a compare or a zero result
// finishes. Binary GCD steps on the 129-bit values and two divisions follow.
// Reset is synchronous and active low; it clears the sequencer and the
// output valid flag. A result waits in the output register while the next
// transaction is accepted; the sequencer only stalls when that is still full.
//
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit import rau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // a_num, a_den, b_num, b_den
    input  logic [2:0]        s_axis_tuser,   // func
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // res_num, res_den, less, equal
    output logic [1:0]        m_axis_tuser    // status
);

    // Command and status between the sequencer and the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;

    // Result fields as seen by the checks below.
    logic [FW-1:0] w_res_num;
    logic [FW-2:0] w_res_den;
    logic          w_is_unit;

    // The sequencer decides the order of the steps; it reads only completion
    // flags, whether the output register is free and whether the result is a fixed 0/1.
    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the operand magnitudes, the products, the GCD
    // state, the divider and the output register.
    rau_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_data   (s_axis_tdata),
        .i_func   (s_axis_tuser),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_status (m_axis_tuser)
    );

    assign w_res_num = m_axis_tdata[FW-1:0];
    assign w_res_den = m_axis_tdata[2*FW-2:FW];
    assign w_is_unit = (w_res_num == '0) && (w_res_den == (FW-1)'(1));

    // Only one transaction is in the sequencer at a time.
    `RAU_AST_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy input")
    // Error and overflow results carry 0/1.
    `RAU_AST_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser != ST_OK, w_is_unit, "error not 0/1")
    // A delivered denominator is never zero.
    `RAU_AST_IMP(a_den_nonzero, m_axis_tvalid, w_res_den != '0, "zero denominator out")

endmodule

>>> hw/rtl/rau_dp.sv
// ============================================================================
// rau_dp
// Datapath: shift-add multiplier, binary GCD, restoring divider, result register.
// ============================================================================
module rau_dp import rau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [IN_DW-1:0]  i_data,
    input  logic [2:0]        i_func,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_DW-1:0] o_data,
    output logic [1:0]        o_status
);

    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic          r_sa, r_sb;
    logic [2:0]    r_func;
    logic [PW-1:0] r_x, r_y, r_d, r_mx, r_acc;
    logic [W-1:0]  r_my;
    logic [MCW-1:0] r_mcnt;
    logic [1:0]    r_mstep;
    logic signed [SW-1:0] r_s;
    logic          r_neg, r_spec, r_lt, r_eq;
    logic [1:0]    r_st;
    logic [MW-1:0] r_u, r_v, r_nm, r_dn, r_dq, r_rem;
    logic [DCW-1:0] r_dcnt;
    logic          r_dsel;
    logic          r_ovalid, r_olt, r_oeq;
    logic [FW-1:0] r_onum;
    logic [FW-2:0] r_oden;
    logic [1:0]    r_ost;

    logic [W-1:0]  l_an, l_ad, l_bn, l_bd;
    logic          l_err;
    logic [W-1:0]  m_l, m_r;
    logic [PW-1:0] m_acc;
    logic          f_unit;
    logic signed [SW-1:0] px, py, sx, qy, s_val;
    logic signed [SW-1:0] a_abs;
    logic [MW-1:0] g_diff;
    logic [MW:0]   d_rem2, d_sub;
    logic          d_ge;
    logic          f_ovf;

    // Operand decode at load time.
    always_comb begin
        l_an = i_data[W-1:0];
        l_ad = i_data[FW+W-1:FW];
        l_bn = i_data[2*FW+W-1:2*FW];
        l_bd = i_data[3*FW+W-1:3*FW];
        case (i_func)
            F_RED, F_NEG:               l_err = (l_ad == '0);
            F_ADD, F_SUB, F_MUL, F_CMP: l_err = (l_ad == '0) || (l_bd == '0);
            F_DIV:     l_err = (l_ad == '0) || (l_bd == '0) || (l_bn == '0);
            default:                    l_err = 1'b0;
        endcase
    end

    // Product operands: step 0 is the numerator term, 1 the cross term, 2 the denominator.
    always_comb begin
        f_unit = (r_func == F_RED) || (r_func == F_NEG);
        case (i_cmd.step)
            2'd0: begin
                m_l = r_an;
                m_r = f_unit ? W'(1) : ((r_func == F_MUL) ? r_bn : r_bd);
            end
            2'd1: begin
                m_l = r_bn;
                m_r = r_ad;
            end
            default: begin
                m_l = r_ad;
                m_r = f_unit ? W'(1) : ((r_func == F_DIV) ? r_bn : r_bd);
            end
        endcase
        m_acc = r_my[0] ? r_acc + r_mx : r_acc;
    end

    // Signed combination of the products.
    always_comb begin
        px = $signed({2'b00, r_x});
        py = $signed({2'b00, r_y});
        sx = r_sa ? -px : px;
        qy = (r_sb ^ (r_func == F_SUB)) ? -py : py;
        case (r_func)
            F_ADD, F_SUB: s_val = sx + qy;
            F_MUL, F_DIV: s_val = (r_sa ^ r_sb) ? -px : px;
            F_NEG:        s_val = r_sa ? px : -px;
            default:      s_val = sx;
        endcase
        a_abs = r_s[SW-1] ? -r_s : r_s;
    end

    always_comb begin
        g_diff = (r_u > r_v) ? r_u - r_v : r_v - r_u;
        d_rem2 = {r_rem, r_dq[MW-1]};
        d_ge   = d_rem2 >= {1'b0, r_u};
        d_sub  = d_rem2 - {1'b0, r_u};
        f_ovf  = (r_dn > LIM_M1) || (r_nm > (r_neg ? LIM : LIM_M1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == DP_FIN) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_an   <= mag(l_an);
                r_ad   <= mag(l_ad);
                r_bn   <= mag(l_bn);
                r_bd   <= mag(l_bd);
                r_sa   <= l_an[W-1] ^ l_ad[W-1];
                r_sb   <= l_bn[W-1] ^ l_bd[W-1];
                r_func <= i_func;
                r_spec <= l_err || (i_func == 3'd7);
                r_st   <= l_err ? ST_ZDEN : ST_OK;
                r_lt   <= 1'b0;
                r_eq   <= 1'b0;
            end
            DP_MUL_START: begin
                r_mx    <= PW'(m_l);
                r_my    <= m_r;
                r_acc   <= '0;
                r_mcnt  <= '0;
                r_mstep <= i_cmd.step;
            end
            DP_MUL_RUN: begin
                r_acc  <= m_acc;
                r_mx   <= r_mx << 1;
                r_my   <= r_my >> 1;
                r_mcnt <= r_mcnt + MCW'(1);
                if (r_mcnt == MCW'(W - 1)) begin
                    case (r_mstep)
                        2'd0:    r_x <= m_acc;
                        2'd1:    r_y <= m_acc;
                        default: r_d <= m_acc;
                    endcase
                end
            end
            DP_COMB: begin
                r_s <= s_val;
                if (r_func == F_CMP) begin
                    r_spec <= 1'b1;
                    r_lt   <= sx < qy;
                    r_eq   <= sx == qy;
                end
            end
            DP_ABS: begin
                r_neg <= r_s[SW-1];
                r_u   <= a_abs[MW-1:0];
                r_nm  <= a_abs[MW-1:0];
                r_v   <= MW'(r_d);
                r_dn  <= MW'(r_d);
                if (r_s == '0) r_spec <= 1'b1;
            end
            DP_GCD: begin
                if (r_u != r_v) begin
                    if (!r_u[0] && !r_v[0]) begin
                        // Common factor of two: strip it from the values too.
                        r_u  <= r_u >> 1;
                        r_v  <= r_v >> 1;
                        r_nm <= r_nm >> 1;
                        r_dn <= r_dn >> 1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u > r_v) begin
                        r_u <= g_diff;
                    end else begin
                        r_v <= g_diff;
                    end
                end
            end
            DP_DIV_START: begin
                r_rem  <= '0;
                r_dq   <= i_cmd.dsel ? r_dn : r_nm;
                r_dcnt <= '0;
                r_dsel <= i_cmd.dsel;
            end
            DP_DIV_RUN: begin
                r_rem  <= d_ge ? d_sub[MW-1:0] : d_rem2[MW-1:0];
                r_dq   <= {r_dq[MW-2:0], d_ge};
                r_dcnt <= r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(MW - 1)) begin
                    if (r_dsel) r_dn <= {r_dq[MW-2:0], d_ge};
                    else        r_nm <= {r_dq[MW-2:0], d_ge};
                end
            end
            DP_FIN: begin
                if (r_spec || f_ovf) begin
                    r_onum <= '0;
                    r_oden <= (FW-1)'(1);
                    r_olt  <= r_spec ? r_lt : 1'b0;
                    r_oeq  <= r_spec ? r_eq : 1'b0;
                    r_ost  <= r_spec ? r_st : ST_OVF;
                end else begin
                    r_onum <= r_neg ? FW'(-r_nm) : FW'(r_nm);
                    r_oden <= (FW-1)'(r_dn);
                    r_olt  <= 1'b0;
                    r_oeq  <= 1'b0;
                    r_ost  <= ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.spec     = r_spec;
    assign o_stat.mul_done = (r_mcnt == MCW'(W - 1));
    assign o_stat.gcd_done = (r_u == r_v);
    assign o_stat.div_done = (r_dcnt == DCW'(MW - 1));
    assign o_stat.out_free = !r_ovalid || i_ready;

    assign o_valid  = r_ovalid;
    assign o_data   = {(OUT_DW - 2*FW - 1)'(0), r_oeq, r_olt, r_oden, r_onum};
    assign o_status = r_ost;

endmodule

>>> hw/rtl/rau_ctrl.sv
// ============================================================================
// rau_ctrl
// Sequencer that steps the datapath through products, GCD and divisions.
// ============================================================================
module rau_ctrl import rau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MSTART, S_MRUN, S_COMB, S_ABS, S_GCD,
        S_DSTART, S_DRUN, S_FIN
    } t_state;

    t_state     r_state;
    logic [1:0] r_step;
    logic       r_dsel;

    always_comb begin
        o_cmd.op   = DP_NOP;
        o_cmd.step = r_step;
        o_cmd.dsel = r_dsel;
        unique case (r_state)
            S_IDLE:   if (i_valid) o_cmd.op = DP_LOAD;
            S_MSTART: o_cmd.op = DP_MUL_START;
            S_MRUN:   o_cmd.op = DP_MUL_RUN;
            S_COMB:   o_cmd.op = DP_COMB;
            S_ABS:    if (!i_stat.spec) o_cmd.op = DP_ABS;
            S_GCD:    if (!i_stat.spec) o_cmd.op = DP_GCD;
            S_DSTART: o_cmd.op = DP_DIV_START;
            S_DRUN:   o_cmd.op = DP_DIV_RUN;
            S_FIN:    if (i_stat.out_free) o_cmd.op = DP_FIN;
            default:  o_cmd.op = DP_NOP;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_dsel  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_CHK;
                S_CHK: begin
                    r_step  <= 2'd0;
                    r_state <= i_stat.spec ? S_FIN : S_MSTART;
                end
                S_MSTART: r_state <= S_MRUN;
                S_MRUN: begin
                    if (i_stat.mul_done) begin
                        if (r_step == 2'd2) begin
                            r_state <= S_COMB;
                        end else begin
                            r_step  <= r_step + 2'd1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_COMB: r_state <= S_ABS;
                S_ABS:  r_state <= i_stat.spec ? S_FIN : S_GCD;
                S_GCD: begin
                    r_dsel <= 1'b0;
                    if (i_stat.spec)          r_state <= S_FIN;
                    else if (i_stat.gcd_done) r_state <= S_DSTART;
                end
                S_DSTART: r_state <= S_DRUN;
                S_DRUN: begin
                    if (i_stat.div_done) begin
                        if (r_dsel) begin
                            r_state <= S_FIN;
                        end else begin
                            r_dsel  <= 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_FIN:   if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
